### rtl/gss_pkg.sv
// Package: shared item types, configuration layout and register indexes for the shaper.
package gss_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  localparam logic [CfgIndexWidth-1:0] CFG_YAW_GAIN     = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_PITCH_GAIN   = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_START_TARGET = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_START_STEP   = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_LOW_LIMIT    = 3'd4;
  localparam logic [CfgIndexWidth-1:0] CFG_HIGH_LIMIT   = 3'd5;

  localparam logic [15:0]        RST_YAW_GAIN     = 16'd10486;
  localparam logic [15:0]        RST_PITCH_GAIN   = 16'd1311;
  localparam logic signed [15:0] RST_START_TARGET = -16'sd1430;
  localparam logic [14:0]        RST_START_STEP   = 15'd12;
  localparam logic signed [15:0] RST_LOW_LIMIT    = -16'sd3399;
  localparam logic signed [15:0] RST_HIGH_LIMIT   = 16'sd0;

  typedef struct packed {
    logic               drive_enable;
    logic               aim_mode;
    logic               aim_fresh;
    logic signed [15:0] aim_yaw_offset;
    logic signed [15:0] aim_pitch_offset;
    logic signed [15:0] measured_yaw;
    logic signed [15:0] measured_pitch;
    logic signed [15:0] manual_yaw_step;
    logic signed [15:0] manual_pitch_step;
  } in_t;

  typedef struct packed {
    logic               active;
    logic signed [15:0] yaw_goal;
    logic signed [15:0] pitch_goal;
    logic signed [15:0] yaw_error;
    logic               start_ramp_finished;
  } out_t;

  typedef struct packed {
    logic [15:0]        yaw_gain;
    logic [15:0]        pitch_gain;
    logic signed [15:0] start_target;
    logic [14:0]        start_step;
    logic signed [15:0] low_limit;
    logic signed [15:0] high_limit;
  } cfg_t;

endpackage

### rtl/gss_cfg_regs.sv
// Configuration register bank with write decoder and reset defaults.
module gss_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gss_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [gss_pkg::CfgDataWidth-1:0]  cfg_data,
  output gss_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.yaw_gain     <= gss_pkg::RST_YAW_GAIN;
      cfg.pitch_gain   <= gss_pkg::RST_PITCH_GAIN;
      cfg.start_target <= gss_pkg::RST_START_TARGET;
      cfg.start_step   <= gss_pkg::RST_START_STEP;
      cfg.low_limit    <= gss_pkg::RST_LOW_LIMIT;
      cfg.high_limit   <= gss_pkg::RST_HIGH_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gss_pkg::CFG_YAW_GAIN:     cfg.yaw_gain     <= cfg_data;
        gss_pkg::CFG_PITCH_GAIN:   cfg.pitch_gain   <= cfg_data;
        gss_pkg::CFG_START_TARGET: cfg.start_target <= $signed(cfg_data);
        gss_pkg::CFG_START_STEP:   cfg.start_step   <= cfg_data[14:0];
        gss_pkg::CFG_LOW_LIMIT:    cfg.low_limit    <= $signed(cfg_data);
        gss_pkg::CFG_HIGH_LIMIT:   cfg.high_limit   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

### rtl/gss_core.sv
// Setpoint state registers and the single-pass shaping logic for one item.
module gss_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  gss_pkg::in_t  item,
  input  gss_pkg::cfg_t cfg,
  output gss_pkg::out_t result
);

  logic signed [15:0] yaw_goal, pitch_goal, yaw_aim, pitch_aim;
  logic               aiming, ramp_done, enabled, seeded;

  logic signed [15:0] yaw_goal_next, pitch_goal_next, yaw_aim_next, pitch_aim_next;
  logic               aiming_next, ramp_done_next, enabled_next;

  logic signed [15:0] yg, pg, yaw_gap;
  logic signed [16:0] pitch_gap, ramp_diff;
  logic [16:0]        ramp_mag;
  logic signed [17:0] yaw_adj, pitch_adj;
  logic               ramp0;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [17:0] frac_mul(input logic signed [16:0] d,
                                                  input logic [15:0] g);
    logic signed [33:0] p;
    p = 34'(d) * $signed({18'd0, g}) + 34'sd32768;
    return p[33:16];
  endfunction

  always_comb begin
    yaw_goal_next   = yaw_goal;
    pitch_goal_next = pitch_goal;
    yaw_aim_next    = yaw_aim;
    pitch_aim_next  = pitch_aim;
    aiming_next     = aiming;
    ramp_done_next  = ramp_done;
    enabled_next    = enabled;
    yaw_gap         = '0;
    pitch_gap       = '0;
    ramp_diff       = '0;
    ramp_mag        = '0;
    yaw_adj         = '0;
    pitch_adj       = '0;
    ramp0           = 1'b0;

    yg = seeded ? yaw_goal : item.measured_yaw;
    pg = pitch_goal;

    if (!item.drive_enable) begin
      pg             = item.measured_pitch;
      ramp_done_next = 1'b0;
      enabled_next   = 1'b0;
    end else begin
      ramp0 = enabled ? ramp_done : 1'b0;
      if (!enabled) begin
        pg = item.measured_pitch;
      end
      enabled_next = 1'b1;
      if (item.aim_mode) begin
        if (!aiming) begin
          yaw_aim_next   = item.measured_yaw;
          pitch_aim_next = item.measured_pitch;
          yg             = item.measured_yaw;
          pg             = item.measured_pitch;
        end
        aiming_next = 1'b1;
        if (item.aim_fresh) begin
          yaw_aim_next   = item.measured_yaw + item.aim_yaw_offset;
          pitch_aim_next = sat16(18'(item.measured_pitch) - 18'(item.aim_pitch_offset));
        end
        yaw_gap = yaw_aim_next - yg;
        yaw_adj = frac_mul(17'(yaw_gap), cfg.yaw_gain);
        yg      = yg + yaw_adj[15:0];
        if (ramp0) begin
          pitch_gap = 17'(pitch_aim_next) - 17'(pg);
          pitch_adj = frac_mul(pitch_gap, cfg.pitch_gain);
          pg        = sat16(18'(pg) + pitch_adj);
        end
      end else begin
        aiming_next = 1'b0;
        yg          = yg + item.manual_yaw_step;
        if (ramp0) begin
          pg = sat16(18'(pg) + 18'(item.manual_pitch_step));
        end
      end
      ramp_done_next = ramp0;
      if (!ramp0) begin
        ramp_diff = 17'(cfg.start_target) - 17'(pg);
        ramp_mag  = ramp_diff[16] ? 17'(-ramp_diff) : 17'(ramp_diff);
        if (ramp_mag <= {2'b00, cfg.start_step}) begin
          pg             = cfg.start_target;
          ramp_done_next = 1'b1;
        end else if (ramp_diff > 17'sd0) begin
          pg = pg + $signed({1'b0, cfg.start_step});
        end else begin
          pg = pg - $signed({1'b0, cfg.start_step});
        end
      end
      if (pg < cfg.low_limit) begin
        pg = cfg.low_limit;
      end
      if (pg > cfg.high_limit) begin
        pg = cfg.high_limit;
      end
    end

    yaw_goal_next   = yg;
    pitch_goal_next = pg;

    result.active              = item.drive_enable;
    result.yaw_goal            = yg;
    result.pitch_goal          = pg;
    result.yaw_error           = yg - item.measured_yaw;
    result.start_ramp_finished = ramp_done_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_goal   <= '0;
      pitch_goal <= '0;
      yaw_aim    <= '0;
      pitch_aim  <= '0;
      aiming     <= 1'b0;
      ramp_done  <= 1'b0;
      enabled    <= 1'b0;
      seeded     <= 1'b0;
    end else if (advance) begin
      yaw_goal   <= yaw_goal_next;
      pitch_goal <= pitch_goal_next;
      yaw_aim    <= yaw_aim_next;
      pitch_aim  <= pitch_aim_next;
      aiming     <= aiming_next;
      ramp_done  <= ramp_done_next;
      enabled    <= enabled_next;
      seeded     <= 1'b1;
    end
  end

endmodule

### rtl/gimbal_setpoint_shaper.sv
// Top level: input register, shaping core and result register of the setpoint shaper.
// A result item passes through the input register and then the result register.
// Throughput: one item per cycle; a stalled result holds the input register,
// which then holds the input.
// Reset (synchronous, active high) empties both stages, clears all setpoint
// state and loads the configuration registers with their defaults.
module gimbal_setpoint_shaper (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  gss_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gss_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [gss_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [gss_pkg::CfgDataWidth-1:0]  cfg_data
);

  gss_pkg::cfg_t cfg;
  gss_pkg::in_t  item;
  gss_pkg::out_t result;
  logic          item_valid;
  logic          advance;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  gss_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gss_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

endmodule
